### rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
// used by spq_cell, sorted_priority_queue_top and spq_checker
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int TAG_BITS      = 16;
  localparam int PRIORITY_BITS = 16;

  // request kind codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;

  // per-cycle operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_op_t;

endpackage

### rtl/spq_cell.sv
// one slot of the sorted shift-register queue
// depends on spq_pkg for the operation struct
module spq_cell #(
  parameter int TAG_BITS      = spq_pkg::TAG_BITS,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS
) (
  input  logic                            clk,
  input  spq_pkg::spq_op_t                op,
  input  logic                            occupied,
  input  logic [TAG_BITS-1:0]             new_tag,
  input  logic signed [PRIORITY_BITS-1:0] new_priority,
  input  logic                            left_behind,
  input  logic [TAG_BITS-1:0]             left_tag,
  input  logic signed [PRIORITY_BITS-1:0] left_priority,
  input  logic [TAG_BITS-1:0]             right_tag,
  input  logic signed [PRIORITY_BITS-1:0] right_priority,
  output logic                            behind,
  output logic [TAG_BITS-1:0]             tag,
  output logic signed [PRIORITY_BITS-1:0] priority_q,
  output logic [TAG_BITS-1:0]             tag_next,
  output logic signed [PRIORITY_BITS-1:0] priority_next
);

  // new entry lands behind this cell when this one is strictly higher
  assign behind = occupied && (priority_q > new_priority);

  always_comb begin
    tag_next      = tag;
    priority_next = priority_q;
    if (op.ins) begin
      if (!behind) begin
        if (left_behind) begin
          tag_next      = new_tag;
          priority_next = new_priority;
        end else begin
          tag_next      = left_tag;
          priority_next = left_priority;
        end
      end
    end else if (op.rem) begin
      tag_next      = right_tag;
      priority_next = right_priority;
    end
  end

  always_ff @(posedge clk) begin
    tag        <= tag_next;
    priority_q <= priority_next;
  end

endmodule

### rtl/sorted_priority_queue_top.sv
// sorted priority queue: a row of CAPACITY cells, head in cell 0
// every cell compares and shifts in parallel; the result is registered and
// shown in the cycle after acceptance; one request per cycle unless in_stall
// reset: clears the entry count and out_valid; cell contents stay
// undefined until written and are never shown while unoccupied
module sorted_priority_queue_top #(
  parameter int CAPACITY      = spq_pkg::CAPACITY,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS,
  localparam int CNT_BITS     = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [TAG_BITS-1:0]             item_tag,
  input  logic signed [PRIORITY_BITS-1:0] item_priority,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic                            head_valid,
  output logic [TAG_BITS-1:0]             head_tag,
  output logic signed [PRIORITY_BITS-1:0] head_priority,
  output logic [CNT_BITS-1:0]             entry_count,
  output logic                            is_full
);

  localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

  logic                      accept;
  logic [CNT_BITS-1:0]       count;
  logic [CNT_BITS-1:0]       count_next;
  logic                      full;
  logic                      empty;
  logic [1:0]                status_next;
  spq_pkg::spq_op_t          op;

  logic [CAPACITY-1:0]                    behind;
  logic [CAPACITY-1:0]                    occupied;
  logic [TAG_BITS-1:0]                    tags       [CAPACITY];
  logic signed [PRIORITY_BITS-1:0]        prios      [CAPACITY];
  logic [TAG_BITS-1:0]                    tags_next  [CAPACITY];
  logic signed [PRIORITY_BITS-1:0]        prios_next [CAPACITY];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CAP_CNT);
  assign empty    = (count == '0);

  always_comb begin
    op          = '0;
    status_next = spq_pkg::STATUS_DONE;
    count_next  = count;
    if (accept) begin
      if (kind == spq_pkg::KIND_INSERT) begin
        if (full) begin
          status_next = spq_pkg::STATUS_FULL;
        end else begin
          op.ins     = 1'b1;
          count_next = count + 1'b1;
        end
      end else begin
        if (empty) begin
          status_next = spq_pkg::STATUS_EMPTY;
        end else begin
          op.rem     = 1'b1;
          count_next = count - 1'b1;
        end
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                            lb;
      logic [TAG_BITS-1:0]             lt;
      logic signed [PRIORITY_BITS-1:0] lp;
      logic [TAG_BITS-1:0]             rt;
      logic signed [PRIORITY_BITS-1:0] rp;

      assign occupied[i] = (count > CNT_BITS'(i));

      if (i == 0) begin : g_first
        assign lb = 1'b1;
        assign lt = '0;
        assign lp = '0;
      end else begin : g_mid
        assign lb = behind[i-1];
        assign lt = tags[i-1];
        assign lp = prios[i-1];
      end

      // last cell goes unoccupied on remove, its contents are don't-care
      if (i == CAPACITY - 1) begin : g_last
        assign rt = '0;
        assign rp = '0;
      end else begin : g_inner
        assign rt = tags[i+1];
        assign rp = prios[i+1];
      end

      spq_cell #(
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
        .clk            (clk),
        .op             (op),
        .occupied       (occupied[i]),
        .new_tag        (item_tag),
        .new_priority   (item_priority),
        .left_behind    (lb),
        .left_tag       (lt),
        .left_priority  (lp),
        .right_tag      (rt),
        .right_priority (rp),
        .behind         (behind[i]),
        .tag            (tags[i]),
        .priority_q     (prios[i]),
        .tag_next       (tags_next[i]),
        .priority_next  (prios_next[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      status      <= status_next;
      head_valid  <= (count_next != '0);
      head_tag    <= (count_next != '0) ? tags_next[0] : '0;
      head_priority <= (count_next != '0) ? prios_next[0] : '0;
      entry_count <= count_next;
      is_full     <= (count_next == CAP_CNT);
    end
  end

endmodule

### rtl/spq_checker.sv
// port-level checks for sorted_priority_queue_top, attached with bind
// depends on spq_pkg for status codes and default sizes
module spq_checker #(
  parameter int CAPACITY      = spq_pkg::CAPACITY,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS,
  localparam int CNT_BITS     = $clog2(CAPACITY + 1)
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      status,
  input logic                            head_valid,
  input logic [TAG_BITS-1:0]             head_tag,
  input logic signed [PRIORITY_BITS-1:0] head_priority,
  input logic [CNT_BITS-1:0]             entry_count,
  input logic                            is_full
);

  localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

  // every accepted request produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head_valid == (entry_count != '0)))
    else $error("head_valid disagrees with entry_count");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_full == (entry_count == CAP_CNT)))
    else $error("is_full disagrees with entry_count");

  a_reject_only_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == spq_pkg::STATUS_FULL) |-> is_full)
    else $error("insert rejected while not full");

  // an ignored remove leaves the queue empty, and an empty head reads zero
  a_ignore_only_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == spq_pkg::STATUS_EMPTY) |->
      (!head_valid && head_tag == '0 && head_priority == '0))
    else $error("remove ignored while not empty");

endmodule

bind sorted_priority_queue_top spq_checker #(
  .CAPACITY      (CAPACITY),
  .TAG_BITS      (TAG_BITS),
  .PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (.*);

### test/sorted_priority_queue_top_tb.sv
// testbench for sorted_priority_queue_top: inserts and removes checked against an in-bench
// sorted-array predictor under random valid and stall gaps
// depends on spq_pkg and the sorted_priority_queue_top rtl
module sorted_priority_queue_top_tb;

  localparam int CAPACITY        = spq_pkg::CAPACITY;
  localparam int TAG_BITS        = spq_pkg::TAG_BITS;
  localparam int PRIORITY_BITS   = spq_pkg::PRIORITY_BITS;
  localparam int CNT_W           = $clog2(CAPACITY + 1);
  localparam int IDLE_PCT        = 22;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_REQUESTS = 1100;

  typedef struct {
    logic                            op;
    logic [TAG_BITS-1:0]             tag;
    logic signed [PRIORITY_BITS-1:0] pri;
    bit                              hold;
  } request_t;

  typedef struct packed {
    logic [1:0]                      status;
    logic                            head_valid;
    logic [TAG_BITS-1:0]             tag;
    logic signed [PRIORITY_BITS-1:0] pri;
    logic [CNT_W-1:0]                count;
    logic                            full;
  } queue_view_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            kind = spq_pkg::KIND_INSERT;
  logic [TAG_BITS-1:0]             item_tag = '0;
  logic signed [PRIORITY_BITS-1:0] item_priority = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      status;
  logic                            head_valid;
  logic [TAG_BITS-1:0]             head_tag;
  logic signed [PRIORITY_BITS-1:0] head_priority;
  logic [CNT_W-1:0]                entry_count;
  logic                            is_full;

  request_t    pending[$];
  queue_view_t expected_views[$];
  int          requests_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;

  // predictor copy of the queue, head in slot 0
  logic [TAG_BITS-1:0]             held_tag[CAPACITY];
  logic signed [PRIORITY_BITS-1:0] held_pri[CAPACITY];
  int                              held = 0;

  // no idling on either side over one long stretch of requests
  wire quiet = (requests_sent >= 400) && (requests_sent < 650);

  sorted_priority_queue_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .item_tag     (item_tag),
    .item_priority(item_priority),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .head_valid   (head_valid),
    .head_tag     (head_tag),
    .head_priority(head_priority),
    .entry_count  (entry_count),
    .is_full      (is_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic queue_view_t apply_request(input logic op,
                                                input logic [TAG_BITS-1:0] tag,
                                                input logic signed [PRIORITY_BITS-1:0] pri);
    queue_view_t v;
    int pos;
    v.status = spq_pkg::STATUS_DONE;
    if (op == spq_pkg::KIND_INSERT) begin
      if (held == CAPACITY) begin
        v.status = spq_pkg::STATUS_FULL;
      end else begin
        // new entry goes behind strictly greater priorities only
        pos = 0;
        while (pos < held && held_pri[pos] > pri) pos++;
        for (int i = held; i > pos; i--) begin
          held_tag[i] = held_tag[i-1];
          held_pri[i] = held_pri[i-1];
        end
        held_tag[pos] = tag;
        held_pri[pos] = pri;
        held++;
      end
    end else if (held == 0) begin
      v.status = spq_pkg::STATUS_EMPTY;
    end else begin
      for (int i = 1; i < held; i++) begin
        held_tag[i-1] = held_tag[i];
        held_pri[i-1] = held_pri[i];
      end
      held--;
    end
    v.head_valid = (held != 0);
    v.tag        = (held != 0) ? held_tag[0] : '0;
    v.pri        = (held != 0) ? held_pri[0] : '0;
    v.count      = CNT_W'(held);
    v.full       = (held == CAPACITY);
    return v;
  endfunction

  task automatic add_request(input logic op, input logic [TAG_BITS-1:0] tag,
                             input logic [PRIORITY_BITS-1:0] pri, input bit hold = 1'b0);
    request_t r;
    r.op   = op;
    r.tag  = tag;
    r.pri  = pri;
    r.hold = hold;
    pending.push_back(r);
  endtask

  task automatic note_failure(input string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      requests_sent <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_views.push_back(apply_request(kind, item_tag, item_priority));
        requests_sent <= requests_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        // a held request waits until every earlier result is back
        if (pending.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT) &&
            !(pending[0].hold && (in_valid || requests_sent != results_seen))) begin
          in_valid <= 1'b1;
          kind <= pending[0].op;
          item_tag <= pending[0].tag;
          item_priority <= pending[0].pri;
          void'(pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    queue_view_t want;
    if (rst) begin
      out_stall <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_views.size() == 0) begin
          note_failure("result with no request outstanding");
        end else begin
          want = expected_views.pop_front();
          if (status !== want.status || head_valid !== want.head_valid ||
              head_tag !== want.tag || head_priority !== want.pri ||
              entry_count !== want.count || is_full !== want.full)
            note_failure($sformatf(
              "want st=%0d hv=%0d tag=%h pri=%0d cnt=%0d full=%0d, got %0d %0d %h %0d %0d %0d",
              want.status, want.head_valid, want.tag, want.pri, want.count, want.full,
              status, head_valid, head_tag, head_priority, entry_count, is_full));
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int span;
    int ins_pct;
    logic [PRIORITY_BITS-1:0] pri;

    // directed: empty remove, extremes, equal priorities, fill to full, drain a few
    add_request(spq_pkg::KIND_REMOVE, 16'h1234, 16'h7fff);
    add_request(spq_pkg::KIND_INSERT, 16'hffff, 16'h7fff);
    add_request(spq_pkg::KIND_INSERT, 16'h0000, 16'h8000);
    add_request(spq_pkg::KIND_INSERT, 16'h0001, 16'h0000);
    add_request(spq_pkg::KIND_INSERT, 16'h0002, 16'h0000);
    add_request(spq_pkg::KIND_INSERT, 16'h0003, 16'hffff);
    add_request(spq_pkg::KIND_INSERT, 16'h0004, 16'h0001);
    add_request(spq_pkg::KIND_INSERT, 16'h0005, 16'h7fff);
    add_request(spq_pkg::KIND_INSERT, 16'h0006, 16'h8000);
    for (int i = 0; i < 8; i++)
      add_request(spq_pkg::KIND_INSERT, 16'ha5a0 + 16'(i),
                  (i % 2) ? 16'(100 * i) : 16'(-100 * i));
    add_request(spq_pkg::KIND_INSERT, 16'hbeef, 16'h0000);
    repeat (5) add_request(spq_pkg::KIND_REMOVE, 16'h0000, 16'h0000);

    // random: phases that lean toward filling, mixing or draining
    n = 0;
    while (n < RANDOM_REQUESTS) begin
      span = $urandom_range(60, 10);
      case ($urandom_range(2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      for (int k = 0; k < span && n < RANDOM_REQUESTS; k++) begin
        case ($urandom_range(3))
          0: pri = 16'($urandom_range(4)) - 16'd2;
          1: pri = $urandom_range(1) ? 16'h7fff : 16'h8000;
          default: pri = 16'($urandom);
        endcase
        add_request(($urandom_range(99) < ins_pct) ? spq_pkg::KIND_INSERT
                                                   : spq_pkg::KIND_REMOVE,
                    16'($urandom), pri, (n % 300) == 0);
        n++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (requests_sent != results_seen) @(posedge clk);
    repeat (5) @(posedge clk);
    if (expected_views.size() != 0) note_failure("results still outstanding at end");
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
